[rtl/core/aqta_pkg.sv]
package aqta_pkg;

   // default ring depth per gas
   localparam int unsigned WINDOW_DEFAULT = 16;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned LEVEL_W  = 3;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CO2_LIMIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TVOC_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUZZER_ENABLE = 2'd2;

   // quality grades
   localparam logic [LEVEL_W-1:0] LVL_EXCELLENT = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_FINE      = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_MODERATE  = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_POOR      = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_VERY_POOR = 3'd4;
   localparam logic [LEVEL_W-1:0] LVL_SEVERE    = 3'd5;

   // grade steps, ppm and ppb
   localparam logic [SAMPLE_W-1:0] CO2_STEP_1  = 16'd400;
   localparam logic [SAMPLE_W-1:0] CO2_STEP_2  = 16'd1000;
   localparam logic [SAMPLE_W-1:0] CO2_STEP_3  = 16'd1500;
   localparam logic [SAMPLE_W-1:0] CO2_STEP_4  = 16'd2000;
   localparam logic [SAMPLE_W-1:0] CO2_STEP_5  = 16'd5000;
   localparam logic [SAMPLE_W-1:0] TVOC_STEP_1 = 16'd50;
   localparam logic [SAMPLE_W-1:0] TVOC_STEP_2 = 16'd100;
   localparam logic [SAMPLE_W-1:0] TVOC_STEP_3 = 16'd150;
   localparam logic [SAMPLE_W-1:0] TVOC_STEP_4 = 16'd200;
   localparam logic [SAMPLE_W-1:0] TVOC_STEP_5 = 16'd300;

   // what a lane reports to the merge side
   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] avg;
   } lane_stat_type;

   // one result beat
   typedef struct packed {
      logic                buzzer_on;
      logic                alarm_active;
      logic [LEVEL_W-1:0]  quality_level;
      logic [SAMPLE_W-1:0] tvoc_average;
      logic [SAMPLE_W-1:0] co2_average;
   } result_type;

endpackage

[rtl/core/aqta_lane.sv]
module aqta_lane #(
   parameter int unsigned WINDOW = aqta_pkg::WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [aqta_pkg::SAMPLE_W-1:0]       sample,
   input  logic [(WINDOW > 1 ? $clog2(WINDOW) : 1)-1:0] wr_slot,
   input  logic [$clog2(WINDOW+1)-1:0]         count,
   input  logic                                drain,
   output aqta_pkg::lane_stat_type             stat
);

   localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CW = $clog2(WINDOW + 1);
   localparam int unsigned SW = aqta_pkg::SAMPLE_W + CW;
   localparam int unsigned BW = $clog2(SW + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_TRIM,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [aqta_pkg::SAMPLE_W-1:0] win_mem_ff [WINDOW];
   logic [aqta_pkg::SAMPLE_W-1:0] rd_data_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [aqta_pkg::SAMPLE_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] div_ff, div_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [CW:0]   rem_ff, rem_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [aqta_pkg::SAMPLE_W-1:0] avg_ff, avg_in;

   logic          issue;
   logic [CW:0]   rem_sh;
   logic          q_bit;

   assign issue = (state_ff == ST_WALK) && (ptr_ff < cnt_ff);
   assign rem_sh = {rem_ff[CW-1:0], quo_ff[SW-1]};
   assign q_bit = (rem_sh >= {1'b0, div_ff});

   // ring storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         win_mem_ff[wr_slot] <= sample;
      end
      rd_data_ff <= win_mem_ff[ptr_ff[AW-1:0]];
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      acc_in    = acc_ff;
      rd_vld_in = issue;
      sum_in    = sum_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      avg_in    = avg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_WALK;
               cnt_in   = count;
               ptr_in   = '0;
               acc_in   = '0;
               sum_in   = '0;
            end
         end
         ST_WALK: begin
            if (issue) begin
               ptr_in = ptr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + SW'(rd_data_ff);
               acc_in = acc_ff + CW'(1);
               if (acc_ff == '0) begin
                  lo_in = rd_data_ff;
                  hi_in = rd_data_ff;
               end else begin
                  if (rd_data_ff < lo_ff) lo_in = rd_data_ff;
                  if (rd_data_ff > hi_ff) hi_in = rd_data_ff;
               end
               if (acc_ff + CW'(1) == cnt_ff) begin
                  state_in = ST_TRIM;
               end
            end
         end
         ST_TRIM: begin
            // drop one smallest and one largest when more than two held
            if (cnt_ff > CW'(2)) begin
               quo_in = sum_ff - SW'(lo_ff) - SW'(hi_ff);
               div_in = cnt_ff - CW'(2);
            end else begin
               quo_in = sum_ff;
               div_in = cnt_ff;
            end
            rem_in   = '0;
            bit_in   = BW'(SW);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in = q_bit ? (rem_sh - {1'b0, div_ff}) : rem_sh;
            quo_in = {quo_ff[SW-2:0], q_bit};
            bit_in = bit_ff - BW'(1);
            if (bit_ff == BW'(1)) begin
               avg_in   = quo_in[aqta_pkg::SAMPLE_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (drain) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
      cnt_ff <= cnt_in;
      ptr_ff <= ptr_in;
      acc_ff <= acc_in;
      sum_ff <= sum_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      avg_ff <= avg_in;
   end

   assign stat.done = (state_ff == ST_DONE);
   assign stat.avg  = avg_ff;

endmodule

[rtl/core/aqta_merge.sv]
module aqta_merge (
   input  aqta_pkg::lane_stat_type        co2_stat,
   input  aqta_pkg::lane_stat_type        tvoc_stat,
   input  logic [aqta_pkg::SAMPLE_W-1:0]  co2_limit,
   input  logic [aqta_pkg::SAMPLE_W-1:0]  tvoc_limit,
   input  logic                           buzzer_enable,
   output aqta_pkg::result_type           result
);

   logic [aqta_pkg::LEVEL_W-1:0] co2_grade;
   logic [aqta_pkg::LEVEL_W-1:0] tvoc_grade;
   logic                         alarm;

   always_comb begin
      if (co2_stat.avg < aqta_pkg::CO2_STEP_1)      co2_grade = aqta_pkg::LVL_EXCELLENT;
      else if (co2_stat.avg < aqta_pkg::CO2_STEP_2) co2_grade = aqta_pkg::LVL_FINE;
      else if (co2_stat.avg < aqta_pkg::CO2_STEP_3) co2_grade = aqta_pkg::LVL_MODERATE;
      else if (co2_stat.avg < aqta_pkg::CO2_STEP_4) co2_grade = aqta_pkg::LVL_POOR;
      else if (co2_stat.avg < aqta_pkg::CO2_STEP_5) co2_grade = aqta_pkg::LVL_VERY_POOR;
      else                                           co2_grade = aqta_pkg::LVL_SEVERE;
   end

   always_comb begin
      if (tvoc_stat.avg < aqta_pkg::TVOC_STEP_1)      tvoc_grade = aqta_pkg::LVL_EXCELLENT;
      else if (tvoc_stat.avg < aqta_pkg::TVOC_STEP_2) tvoc_grade = aqta_pkg::LVL_FINE;
      else if (tvoc_stat.avg < aqta_pkg::TVOC_STEP_3) tvoc_grade = aqta_pkg::LVL_MODERATE;
      else if (tvoc_stat.avg < aqta_pkg::TVOC_STEP_4) tvoc_grade = aqta_pkg::LVL_POOR;
      else if (tvoc_stat.avg < aqta_pkg::TVOC_STEP_5) tvoc_grade = aqta_pkg::LVL_VERY_POOR;
      else                                             tvoc_grade = aqta_pkg::LVL_SEVERE;
   end

   assign alarm = (co2_stat.avg > co2_limit) || (tvoc_stat.avg > tvoc_limit);

   assign result.co2_average   = co2_stat.avg;
   assign result.tvoc_average  = tvoc_stat.avg;
   assign result.quality_level = (co2_grade < tvoc_grade) ? tvoc_grade : co2_grade;
   assign result.alarm_active  = alarm;
   assign result.buzzer_on     = alarm & buzzer_enable;

endmodule

[rtl/core/air_quality_trimmed_average_alarm_core.sv]
// trimmed moving average of co2 and tvoc with a six-level quality grade and an alarm.
// each request beat carries one co2 and one tvoc sample; both go into their own ring
// of WINDOW entries at the same slot, and exactly one response beat comes back per
// request. two identical lanes walk their rings in parallel, one stored entry per
// cycle through a registered memory read, accumulating sum, minimum and maximum; with
// more than two entries held the smallest and largest are dropped, then a restoring
// divider gives one quotient bit per cycle. between request beat and loaded response
// the lanes pass through the ring walk over all entries held (up to WINDOW), a trim
// step, the serial divide of SW = 16 + clog2(WINDOW+1) quotient bits and the done
// state that holds the averages. one item is in work at a time; a new request beat
// is taken as soon as the previous result sits in the response register, even while
// that beat still waits for rsp_tready. the merge stage grades both averages
// (co2 steps 400/1000/1500/2000/5000 ppm, tvoc steps 50/100/150/200/300 ppb),
// takes the worse grade and raises the alarm when either average is strictly above its
// limit; buzzer_on is the alarm gated by buzzer_enable. configuration (index 0 co2
// limit, 1 tvoc limit, 2 buzzer enable, others ignored) is always ready and should be
// written only while the block is idle. ring contents are not cleared by reset; only
// entries already written are ever averaged.
module air_quality_trimmed_average_alarm_core #(
   parameter int unsigned WINDOW = aqta_pkg::WINDOW_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // co2_sample[15:0], tvoc_sample[31:16]

   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // co2_average[15:0], tvoc_average[31:16], quality_level[34:32],
   // alarm_active[35], buzzer_on[36], zero fill [39:37]
   output logic [39:0]                       rsp_tdata,

   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aqta_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aqta_pkg::SAMPLE_W-1:0]     csr_data
);

   localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CW = $clog2(WINDOW + 1);

   // configuration registers
   logic [aqta_pkg::SAMPLE_W-1:0] co2_limit_ff, co2_limit_in;
   logic [aqta_pkg::SAMPLE_W-1:0] tvoc_limit_ff, tvoc_limit_in;
   logic                          buzzer_en_ff, buzzer_en_in;

   // ring position shared by both lanes
   logic [AW-1:0] slot_ff, slot_in;
   logic [CW-1:0] fill_ff, fill_in;

   logic          busy_ff, busy_in;
   logic          rsp_vld_ff, rsp_vld_in;
   aqta_pkg::result_type rsp_data_ff, rsp_data_in;

   logic                    req_beat;
   logic                    load;
   aqta_pkg::lane_stat_type co2_stat;
   aqta_pkg::lane_stat_type tvoc_stat;
   aqta_pkg::result_type    merged;

   assign csr_ready  = 1'b1;
   assign req_tready = ~busy_ff;
   assign req_beat   = req_tvalid & req_tready;

   // both lanes finish together; hand over once the response register is free
   assign load = co2_stat.done & tvoc_stat.done & (~rsp_vld_ff | rsp_tready);

   aqta_lane #(
      .WINDOW (WINDOW)
   ) u_co2_lane (
      .clock   (clock),
      .reset   (reset),
      .start   (req_beat),
      .sample  (req_tdata[15:0]),
      .wr_slot (slot_ff),
      .count   (fill_in),
      .drain   (load),
      .stat    (co2_stat)
   );

   aqta_lane #(
      .WINDOW (WINDOW)
   ) u_tvoc_lane (
      .clock   (clock),
      .reset   (reset),
      .start   (req_beat),
      .sample  (req_tdata[31:16]),
      .wr_slot (slot_ff),
      .count   (fill_in),
      .drain   (load),
      .stat    (tvoc_stat)
   );

   aqta_merge u_merge (
      .co2_stat      (co2_stat),
      .tvoc_stat     (tvoc_stat),
      .co2_limit     (co2_limit_ff),
      .tvoc_limit    (tvoc_limit_ff),
      .buzzer_enable (buzzer_en_ff),
      .result        (merged)
   );

   always_comb begin
      co2_limit_in  = co2_limit_ff;
      tvoc_limit_in = tvoc_limit_ff;
      buzzer_en_in  = buzzer_en_ff;
      if (csr_valid & csr_ready) begin
         case (csr_index)
            aqta_pkg::CSR_CO2_LIMIT:     co2_limit_in  = csr_data;
            aqta_pkg::CSR_TVOC_LIMIT:    tvoc_limit_in = csr_data;
            aqta_pkg::CSR_BUZZER_ENABLE: buzzer_en_in  = csr_data[0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_comb begin
      // fill count saturates at the ring depth, slot wraps
      fill_in = (fill_ff < CW'(WINDOW)) ? (fill_ff + CW'(1)) : fill_ff;
      if (!req_beat) begin
         fill_in = fill_ff;
      end
      slot_in = slot_ff;
      if (req_beat) begin
         slot_in = (slot_ff == AW'(WINDOW - 1)) ? '0 : (slot_ff + AW'(1));
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_vld_ff & rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = merged;
         busy_in     = 1'b0;
      end
      if (req_beat) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         co2_limit_ff  <= '0;
         tvoc_limit_ff <= '0;
         buzzer_en_ff  <= 1'b0;
         slot_ff       <= '0;
         fill_ff       <= '0;
         busy_ff       <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         co2_limit_ff  <= co2_limit_in;
         tvoc_limit_ff <= tvoc_limit_in;
         buzzer_en_ff  <= buzzer_en_in;
         slot_ff       <= slot_in;
         fill_ff       <= fill_in;
         busy_ff       <= busy_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

endmodule

[dv/tb_air_quality_trimmed_average_alarm_core.sv]
`timescale 1ns / 1ps

module tb_air_quality_trimmed_average_alarm_core;

   localparam int unsigned RING_DEPTH     = aqta_pkg::WINDOW_DEFAULT;
   localparam int unsigned PARK_CYCLES    = 300;     // long response hold-off
   localparam int unsigned DRAIN_CYCLES   = 64;      // settle time before the verdict
   localparam int unsigned TIMEOUT_CYCLES = 600_000;
   localparam int unsigned MAX_REPORTED   = 10;

   // register index the block has no register for
   localparam logic [aqta_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // clock and reset
   logic clock;
   logic reset = 1'b1;

   // block ports, all known from time zero
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [31:0]                    req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [39:0]                    rsp_tdata;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [aqta_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [aqta_pkg::SAMPLE_W-1:0]  csr_data   = '0;

   // sample pairs waiting to go out, {tvoc, co2} as on the request bus
   logic [31:0] sample_pairs_q[$];
   // predicted response beats, oldest first
   aqta_pkg::result_type air_reports_due[$];
   int unsigned bad_reports = 0;

   // traffic shaping
   logic        calm         = 1'b0;   // no idling on either side
   logic        park_request = 1'b0;   // one-cycle pulse starts the long hold-off
   int unsigned gap_left     = 0;
   int unsigned stall_left   = 0;
   int unsigned park_left    = 0;

   // predictor state: both rings, write slot, fill count and the registers
   logic [aqta_pkg::SAMPLE_W-1:0] co2_ring [RING_DEPTH];
   logic [aqta_pkg::SAMPLE_W-1:0] tvoc_ring[RING_DEPTH];
   int unsigned                   ring_slot;
   int unsigned                   ring_fill;
   logic [aqta_pkg::SAMPLE_W-1:0] co2_lim;
   logic [aqta_pkg::SAMPLE_W-1:0] tvoc_lim;
   logic                          buzzer_en;

   air_quality_trimmed_average_alarm_core #(
      .WINDOW(RING_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mean over the held entries of one gas; drops one smallest and one largest
   // copy once more than two entries are held, then truncates
   function automatic logic [aqta_pkg::SAMPLE_W-1:0] window_trimmed_mean(
         input logic pick_tvoc);
      logic [31:0]                   sum;
      logic [aqta_pkg::SAMPLE_W-1:0] lo;
      logic [aqta_pkg::SAMPLE_W-1:0] hi;
      logic [aqta_pkg::SAMPLE_W-1:0] v;
      int unsigned                   n;
      int unsigned                   k;
      n = ring_fill;
      if (n == 0) begin
         return '0;
      end
      sum = '0;
      lo  = pick_tvoc ? tvoc_ring[0] : co2_ring[0];
      hi  = lo;
      for (k = 0; k < n; k++) begin
         v   = pick_tvoc ? tvoc_ring[k] : co2_ring[k];
         sum = sum + v;
         if (v > hi) begin
            hi = v;
         end
         if (v < lo) begin
            lo = v;
         end
      end
      if (n > 2) begin
         n   = n - 2;
         sum = sum - lo - hi;
      end
      return aqta_pkg::SAMPLE_W'(sum / n);
   endfunction

   function automatic logic [aqta_pkg::LEVEL_W-1:0] co2_grade(
         input logic [aqta_pkg::SAMPLE_W-1:0] v);
      if (v < aqta_pkg::CO2_STEP_1) return aqta_pkg::LVL_EXCELLENT;
      if (v < aqta_pkg::CO2_STEP_2) return aqta_pkg::LVL_FINE;
      if (v < aqta_pkg::CO2_STEP_3) return aqta_pkg::LVL_MODERATE;
      if (v < aqta_pkg::CO2_STEP_4) return aqta_pkg::LVL_POOR;
      if (v < aqta_pkg::CO2_STEP_5) return aqta_pkg::LVL_VERY_POOR;
      return aqta_pkg::LVL_SEVERE;
   endfunction

   function automatic logic [aqta_pkg::LEVEL_W-1:0] tvoc_grade(
         input logic [aqta_pkg::SAMPLE_W-1:0] v);
      if (v < aqta_pkg::TVOC_STEP_1) return aqta_pkg::LVL_EXCELLENT;
      if (v < aqta_pkg::TVOC_STEP_2) return aqta_pkg::LVL_FINE;
      if (v < aqta_pkg::TVOC_STEP_3) return aqta_pkg::LVL_MODERATE;
      if (v < aqta_pkg::TVOC_STEP_4) return aqta_pkg::LVL_POOR;
      if (v < aqta_pkg::TVOC_STEP_5) return aqta_pkg::LVL_VERY_POOR;
      return aqta_pkg::LVL_SEVERE;
   endfunction

   // store one sample pair and work out the response beat it causes
   function automatic aqta_pkg::result_type air_report_for(
         input logic [aqta_pkg::SAMPLE_W-1:0] co2,
         input logic [aqta_pkg::SAMPLE_W-1:0] tvoc);
      aqta_pkg::result_type         r;
      logic [aqta_pkg::LEVEL_W-1:0] g_co2;
      logic [aqta_pkg::LEVEL_W-1:0] g_tvoc;
      co2_ring[ring_slot]  = co2;
      tvoc_ring[ring_slot] = tvoc;
      ring_slot = (ring_slot + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) begin
         ring_fill = ring_fill + 1;
      end
      r.co2_average   = window_trimmed_mean(1'b0);
      r.tvoc_average  = window_trimmed_mean(1'b1);
      g_co2           = co2_grade(r.co2_average);
      g_tvoc          = tvoc_grade(r.tvoc_average);
      r.quality_level = (g_co2 < g_tvoc) ? g_tvoc : g_co2;
      r.alarm_active  = (r.co2_average > co2_lim) || (r.tvoc_average > tvoc_lim);
      r.buzzer_on     = r.alarm_active & buzzer_en;
      return r;
   endfunction

   // request driver: pops the next pair whenever the bus is free, with random gaps
   always @(posedge clock) begin : req_driver
      logic        valid_n;
      logic [31:0] data_n;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_left   <= 0;
      end else begin
         valid_n = req_tvalid;
         data_n  = req_tdata;
         // a held beat stays put until taken
         if (!req_tvalid || req_tready) begin
            valid_n = 1'b0;
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end else if (sample_pairs_q.size() != 0) begin
               if (!calm && $urandom_range(0, 5) == 0) begin
                  // idle burst: this one plus gap_left more
                  gap_left <= $urandom_range(0, 3);
               end else begin
                  valid_n = 1'b1;
                  data_n  = sample_pairs_q.pop_front();
               end
            end
         end
         req_tvalid <= valid_n;
         req_tdata  <= data_n;
      end
   end

   // response ready: short random stalls, plus one long hold-off on request
   always @(posedge clock) begin : rsp_receiver
      logic ready_n;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         park_left  <= 0;
      end else begin
         ready_n = 1'b1;
         if (park_request) begin
            park_left <= PARK_CYCLES;
            ready_n   = 1'b0;
         end else if (park_left != 0) begin
            park_left <= park_left - 1;
            ready_n   = 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            ready_n    = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            ready_n    = 1'b0;
         end
         rsp_tready <= ready_n;
      end
   end

   // scoreboard: tracks register writes, predicts on request beats, checks response beats
   always @(posedge clock) begin : air_scoreboard
      aqta_pkg::result_type got;
      aqta_pkg::result_type want;
      if (reset) begin
         ring_slot = 0;
         ring_fill = 0;
         co2_lim   = '0;
         tvoc_lim  = '0;
         buzzer_en = 1'b0;
         air_reports_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               aqta_pkg::CSR_CO2_LIMIT:     co2_lim   = csr_data;
               aqta_pkg::CSR_TVOC_LIMIT:    tvoc_lim  = csr_data;
               aqta_pkg::CSR_BUZZER_ENABLE: buzzer_en = csr_data[0];
               default: ;   // no register there, write dropped
            endcase
         end
         // check before predicting: a beat taken now cannot answer this edge
         if (rsp_tvalid && rsp_tready) begin
            got = aqta_pkg::result_type'(rsp_tdata[36:0]);
            if (air_reports_due.size() == 0) begin
               bad_reports++;
               if (bad_reports <= MAX_REPORTED) begin
                  $display("%0t: response beat with nothing pending: co2 %0d tvoc %0d",
                           $time, got.co2_average, got.tvoc_average);
               end
            end else begin
               want = air_reports_due.pop_front();
               if (got.co2_average   !== want.co2_average   ||
                   got.tvoc_average  !== want.tvoc_average  ||
                   got.quality_level !== want.quality_level ||
                   got.alarm_active  !== want.alarm_active  ||
                   got.buzzer_on     !== want.buzzer_on) begin
                  bad_reports++;
                  if (bad_reports <= MAX_REPORTED) begin
                     $display("%0t: mismatch want co2 %0d tvoc %0d lvl %0d alarm %b buzz %b",
                              $time, want.co2_average, want.tvoc_average,
                              want.quality_level, want.alarm_active, want.buzzer_on);
                     $display("%0t:            got co2 %0d tvoc %0d lvl %0d alarm %b buzz %b",
                              $time, got.co2_average, got.tvoc_average,
                              got.quality_level, got.alarm_active, got.buzzer_on);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            air_reports_due.push_back(air_report_for(req_tdata[15:0], req_tdata[31:16]));
         end
      end
   end

   task automatic write_csr(input logic [aqta_pkg::CSR_IDX_W-1:0] idx,
                            input logic [aqta_pkg::SAMPLE_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   task automatic queue_pair(input logic [aqta_pkg::SAMPLE_W-1:0] co2,
                             input logic [aqta_pkg::SAMPLE_W-1:0] tvoc);
      sample_pairs_q.push_back({tvoc, co2});
   endtask

   // a run level: mostly right at a grade step, else anywhere
   function automatic logic [aqta_pkg::SAMPLE_W-1:0] pick_level(input logic pick_tvoc);
      logic [aqta_pkg::SAMPLE_W-1:0] step;
      case ($urandom_range(0, 7))
         0: step = pick_tvoc ? aqta_pkg::TVOC_STEP_1 : aqta_pkg::CO2_STEP_1;
         1: step = pick_tvoc ? aqta_pkg::TVOC_STEP_2 : aqta_pkg::CO2_STEP_2;
         2: step = pick_tvoc ? aqta_pkg::TVOC_STEP_3 : aqta_pkg::CO2_STEP_3;
         3: step = pick_tvoc ? aqta_pkg::TVOC_STEP_4 : aqta_pkg::CO2_STEP_4;
         4: step = pick_tvoc ? aqta_pkg::TVOC_STEP_5 : aqta_pkg::CO2_STEP_5;
         5: return aqta_pkg::SAMPLE_W'($urandom_range(0, pick_tvoc ? 400 : 6000));
         6: return aqta_pkg::SAMPLE_W'($urandom);
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
      // one below, at, or one above the step
      return aqta_pkg::SAMPLE_W'(step + $urandom_range(0, 2) - 1);
   endfunction

   // runs of steady readings so the window settles on a known level,
   // mixed with jitter, single outliers and plain noise
   task automatic queue_readings(input int unsigned count);
      int unsigned                   run_left;
      int unsigned                   k;
      logic [aqta_pkg::SAMPLE_W-1:0] co2_base;
      logic [aqta_pkg::SAMPLE_W-1:0] tvoc_base;
      logic [aqta_pkg::SAMPLE_W-1:0] co2_v;
      logic [aqta_pkg::SAMPLE_W-1:0] tvoc_v;
      run_left  = 0;
      co2_base  = '0;
      tvoc_base = '0;
      for (k = 0; k < count; k++) begin
         if (run_left == 0) begin
            run_left  = $urandom_range(4, 24);
            co2_base  = pick_level(1'b0);
            tvoc_base = pick_level(1'b1);
         end
         run_left--;
         case ($urandom_range(0, 9))
            0: begin
               co2_v  = aqta_pkg::SAMPLE_W'($urandom);
               tvoc_v = aqta_pkg::SAMPLE_W'($urandom);
            end
            1: begin
               co2_v  = $urandom_range(0, 1) ? '1 : '0;
               tvoc_v = $urandom_range(0, 1) ? '1 : '0;
            end
            2, 3: begin
               co2_v  = co2_base + aqta_pkg::SAMPLE_W'($urandom_range(0, 3));
               tvoc_v = tvoc_base + aqta_pkg::SAMPLE_W'($urandom_range(0, 3));
            end
            default: begin
               co2_v  = co2_base;
               tvoc_v = tvoc_base;
            end
         endcase
         queue_pair(co2_v, tvoc_v);
      end
   endtask

   // sender pause: everything sent and every response back
   task automatic wait_idle();
      @(negedge clock);
      while (sample_pairs_q.size() != 0 || req_tvalid || air_reports_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed pass on reset register values (limits 0, buzzer off)
      @(negedge clock);
      queue_pair('0, '0);                // single entry, average equals limit, no alarm
      queue_pair('1, '1);                // two entries, plain mean
      queue_pair('1, '1);                // three entries, first trimming
      queue_pair('0, '0);                // ties at both ends
      repeat (4) queue_pair(aqta_pkg::CO2_STEP_2, aqta_pkg::TVOC_STEP_3);
      queue_pair(16'h5555, 16'hAAAA);
      queue_pair(16'hAAAA, 16'h5555);
      queue_pair(aqta_pkg::CO2_STEP_1 - 16'd1, aqta_pkg::TVOC_STEP_1 - 16'd1);
      queue_pair(aqta_pkg::CO2_STEP_1, aqta_pkg::TVOC_STEP_1);
      queue_pair(aqta_pkg::CO2_STEP_2 - 16'd1, aqta_pkg::TVOC_STEP_2 - 16'd1);
      queue_pair(aqta_pkg::CO2_STEP_2, aqta_pkg::TVOC_STEP_2);
      queue_pair(aqta_pkg::CO2_STEP_3 - 16'd1, aqta_pkg::TVOC_STEP_3 - 16'd1);
      queue_pair(aqta_pkg::CO2_STEP_3, aqta_pkg::TVOC_STEP_3);
      queue_pair(aqta_pkg::CO2_STEP_4 - 16'd1, aqta_pkg::TVOC_STEP_4 - 16'd1);
      queue_pair(aqta_pkg::CO2_STEP_4, aqta_pkg::TVOC_STEP_4);
      // window full and write slot wrapped by now
      queue_pair(aqta_pkg::CO2_STEP_5 - 16'd1, aqta_pkg::TVOC_STEP_5 - 16'd1);
      // oldest entries keep being overwritten
      queue_pair(aqta_pkg::CO2_STEP_5, aqta_pkg::TVOC_STEP_5);
      queue_pair('1, '0);
      queue_pair('0, '1);
      wait_idle();

      // mid limits, buzzer on, plus a write to the unused index
      write_csr(aqta_pkg::CSR_CO2_LIMIT, aqta_pkg::CO2_STEP_2);
      write_csr(aqta_pkg::CSR_TVOC_LIMIT, aqta_pkg::TVOC_STEP_3);
      write_csr(aqta_pkg::CSR_BUZZER_ENABLE, 16'h0001);
      write_csr(CSR_SPARE, 16'h1234);
      @(negedge clock);
      queue_readings(380);
      // hold responses off long enough for the request side to back up
      @(posedge clock);
      park_request <= 1'b1;
      @(posedge clock);
      park_request <= 1'b0;
      wait_idle();

      // top limits never alarm; upper data bits of the enable are dropped
      write_csr(aqta_pkg::CSR_CO2_LIMIT, '1);
      write_csr(aqta_pkg::CSR_TVOC_LIMIT, '1);
      write_csr(aqta_pkg::CSR_BUZZER_ENABLE, 16'hFFFE);
      @(negedge clock);
      queue_readings(380);
      wait_idle();

      // co2 limit at zero, tvoc at top
      write_csr(aqta_pkg::CSR_CO2_LIMIT, '0);
      write_csr(aqta_pkg::CSR_TVOC_LIMIT, '1);
      write_csr(aqta_pkg::CSR_BUZZER_ENABLE, 16'hFFFF);
      @(negedge clock);
      queue_readings(380);
      wait_idle();

      // random limits around the grade range, full speed on both sides
      write_csr(aqta_pkg::CSR_CO2_LIMIT,
                aqta_pkg::SAMPLE_W'($urandom_range(aqta_pkg::CO2_STEP_1,
                                                   aqta_pkg::CO2_STEP_5)));
      write_csr(aqta_pkg::CSR_TVOC_LIMIT,
                aqta_pkg::SAMPLE_W'($urandom_range(aqta_pkg::TVOC_STEP_1,
                                                   aqta_pkg::TVOC_STEP_5)));
      write_csr(aqta_pkg::CSR_BUZZER_ENABLE, 16'h0001);
      @(negedge clock);
      calm <= 1'b1;
      queue_readings(460);
      wait_idle();

      // let any stray beat show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_reports == 0 && air_reports_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 10);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
